/* rtl/core/wsst_pkg.sv */
// shared types and constants of the weighted sample sum tree
`default_nettype none
package wsst_pkg;

    localparam int IDX_W = 10;
    localparam int WGT_W = 32;
    localparam int RND_W = 32;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    typedef enum logic {
        OP_ADD,
        OP_SUB
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DN_RD,
        ST_DN_CMP,
        ST_EMIT,
        ST_UP_RD,
        ST_UP_SUM
    } t_state;

endpackage
`default_nettype wire

/* rtl/core/wsst_channels.sv */
// handshake channels for the request and result items
`default_nettype none
interface wsst_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [wsst_pkg::IDX_W-1:0] object_index;
    logic [wsst_pkg::WGT_W-1:0] weight;
    logic [wsst_pkg::RND_W-1:0] random_fraction;

    modport source(output valid, kind, object_index, weight, random_fraction, input ready);
    modport sink(input valid, kind, object_index, weight, random_fraction, output ready);
endinterface

interface wsst_out_if;
    logic                      valid;
    logic                      ready;
    logic [wsst_pkg::IDX_W-1:0] chosen_index;
    logic                      nothing_left;

    modport source(output valid, chosen_index, nothing_left, input ready);
    modport sink(input valid, chosen_index, nothing_left, output ready);
endinterface
`default_nettype wire

/* rtl/core/wsst_alu.sv */
// shared adder / subtractor used for scaling, descent compare and path sums
`default_nettype none
module wsst_alu #(
    parameter int W = 42
) (
    input  wire logic [W-1:0]          i_a,
    input  wire logic [W-1:0]          i_b,
    input  wire wsst_pkg::t_alu_op     i_op,
    output logic      [W:0]            o_res
);

    // top bit is carry on add, borrow on subtract
    always_comb begin
        unique case (i_op)
            wsst_pkg::OP_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            wsst_pkg::OP_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/wsst_node_ram.sv */
// node sum memory, one write and one registered read port
`default_nettype none
module wsst_node_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 42
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/core/weighted_sample_sum_tree_core.sv */
// top level: sum tree sequencer for weighted draws without replacement
`default_nettype none
// Keeps object weights in the leaves of a binary sum tree held in one node RAM
// (one write and one registered read per cycle) and walks it with a single
// shared adder/subtractor under a small sequencer; the block takes one item at
// a time. After reset a clearing pass zeroes all 2*2^ceil(log2(LEAF_COUNT))
// nodes before the first item is taken. A weight write does one node read and
// one node write per tree level on the way to the root. A draw scales the root
// total bit-serially through the adder, descends the tree with one node read
// and one compare per level, then zeroes the leaf and rebuilds its path. A draw
// on an empty tree skips the scaling and the descent and answers directly. The
// result sits in an output register, so the next item is taken while it waits.
module weighted_sample_sum_tree_core #(
    parameter int LEAF_COUNT  = 1024,
    parameter int WEIGHT_BITS = 32,
    parameter int RANDOM_BITS = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    wsst_in_if.sink       i_in,
    wsst_out_if.source    o_out
);

    localparam int LVL    = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
    localparam int ADDR_W = LVL + 1;
    localparam int WEFF   = (WEIGHT_BITS < wsst_pkg::WGT_W) ? WEIGHT_BITS : wsst_pkg::WGT_W;
    localparam int RB_IN  = (RANDOM_BITS < wsst_pkg::RND_W) ? RANDOM_BITS : wsst_pkg::RND_W;
    localparam int SUM_W  = WEFF + LVL;
    localparam int CNT_W  = $clog2(RANDOM_BITS);
    localparam logic [ADDR_W-1:0] ROOT = ADDR_W'(1);

    wsst_pkg::t_state r_state, n_state;
    logic [ADDR_W-1:0]       r_clr, n_clr;
    logic [SUM_W-1:0]        r_total, n_total;
    logic                    r_out_valid, n_out_valid;
    logic [wsst_pkg::IDX_W-1:0] r_out_index, n_out_index;
    logic                    r_out_empty, n_out_empty;
    logic [ADDR_W-1:0]       r_node, n_node;
    logic [SUM_W-1:0]        r_val, n_val;
    logic [SUM_W-1:0]        r_acc, n_acc;
    logic [RANDOM_BITS-1:0]  r_u, n_u;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_empty, n_empty;

    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [SUM_W-1:0]        mem_wdata, mem_rdata;
    logic [SUM_W-1:0]        alu_a, alu_b;
    wsst_pkg::t_alu_op       alu_op;
    logic [SUM_W:0]          alu_res;

    logic                    out_free;
    logic                    idx_ok;
    logic [ADDR_W-1:0]       leaf_node;
    logic [SUM_W-1:0]        wr_weight;
    logic [ADDR_W-1:0]       dn_node;
    logic [ADDR_W-1:0]       parent;

    wsst_node_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (SUM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    wsst_alu #(
        .W (SUM_W)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    assign out_free  = !r_out_valid || o_out.ready;
    assign idx_ok    = {22'd0, i_in.object_index} < 32'(LEAF_COUNT);
    assign leaf_node = ADDR_W'(2**LVL) + ADDR_W'(i_in.object_index);
    assign wr_weight = SUM_W'(i_in.weight[WEFF-1:0]);
    // go right when the target is not below the left child sum
    assign dn_node   = {r_node[ADDR_W-2:0], !alu_res[SUM_W]};
    assign parent    = {1'b0, r_node[ADDR_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsst_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_index <= n_out_index;
        r_out_empty <= n_out_empty;
        r_node      <= n_node;
        r_val       <= n_val;
        r_acc       <= n_acc;
        r_u         <= n_u;
        r_cnt       <= n_cnt;
        r_empty     <= n_empty;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_index = r_out_index;
        n_out_empty = r_out_empty;
        n_node      = r_node;
        n_val       = r_val;
        n_acc       = r_acc;
        n_u         = r_u;
        n_cnt       = r_cnt;
        n_empty     = r_empty;
        mem_we      = 1'b0;
        mem_waddr   = r_node;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_node;
        alu_a       = r_acc;
        alu_b       = '0;
        alu_op      = wsst_pkg::OP_ADD;
        i_in.ready  = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            wsst_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + ADDR_W'(1);
                if (&r_clr) begin
                    n_state = wsst_pkg::ST_IDLE;
                end
            end
            wsst_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.kind == wsst_pkg::KIND_DRAW) begin
                        n_empty = (r_total == '0);
                        n_acc   = '0;
                        n_u     = RANDOM_BITS'(i_in.random_fraction[RB_IN-1:0]);
                        n_cnt   = CNT_W'(RANDOM_BITS - 1);
                        n_state = (r_total == '0) ? wsst_pkg::ST_EMIT : wsst_pkg::ST_MUL;
                    end else if (idx_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = leaf_node;
                        mem_wdata = wr_weight;
                        n_node    = leaf_node;
                        n_val     = wr_weight;
                        n_state   = wsst_pkg::ST_UP_RD;
                    end
                end
            end
            wsst_pkg::ST_MUL: begin
                // one bit of u per cycle, lsb first, shifting the partial sum down
                alu_a = r_acc;
                alu_b = r_u[0] ? r_total : '0;
                n_acc = alu_res[SUM_W:1];
                n_u   = r_u >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_node  = ROOT;
                    n_state = wsst_pkg::ST_DN_RD;
                end
            end
            wsst_pkg::ST_DN_RD: begin
                mem_re    = 1'b1;
                mem_raddr = {r_node[ADDR_W-2:0], 1'b0};
                n_state   = wsst_pkg::ST_DN_CMP;
            end
            wsst_pkg::ST_DN_CMP: begin
                alu_a  = r_acc;
                alu_b  = mem_rdata;
                alu_op = wsst_pkg::OP_SUB;
                if (!alu_res[SUM_W]) begin
                    n_acc = alu_res[SUM_W-1:0];
                end
                n_node  = dn_node;
                n_state = dn_node[ADDR_W-1] ? wsst_pkg::ST_EMIT : wsst_pkg::ST_DN_RD;
            end
            wsst_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_empty = r_empty;
                    if (r_empty) begin
                        n_out_index = '0;
                        n_state     = wsst_pkg::ST_IDLE;
                    end else begin
                        n_out_index = wsst_pkg::IDX_W'(r_node[LVL-1:0]);
                        // drawn leaf drops out of later draws
                        mem_we      = 1'b1;
                        mem_waddr   = r_node;
                        n_val       = '0;
                        n_state     = wsst_pkg::ST_UP_RD;
                    end
                end
            end
            wsst_pkg::ST_UP_RD: begin
                if (r_node == ROOT) begin
                    n_state = wsst_pkg::ST_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = {r_node[ADDR_W-1:1], ~r_node[0]};
                    n_state   = wsst_pkg::ST_UP_SUM;
                end
            end
            wsst_pkg::ST_UP_SUM: begin
                alu_a     = r_val;
                alu_b     = mem_rdata;
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = alu_res[SUM_W-1:0];
                n_val     = alu_res[SUM_W-1:0];
                n_node    = parent;
                if (parent == ROOT) begin
                    n_total = alu_res[SUM_W-1:0];
                end
                n_state   = wsst_pkg::ST_UP_RD;
            end
        endcase
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.chosen_index = r_out_index;
    assign o_out.nothing_left = r_out_empty;

    a_target_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wsst_pkg::ST_DN_CMP |-> r_acc < r_total)
        else $error("descent target not below the tree total");

    a_emit_at_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wsst_pkg::ST_EMIT && !r_empty |-> r_node[ADDR_W-1])
        else $error("draw result taken from a node that is not a leaf");

    a_no_take_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wsst_pkg::ST_CLEAR |-> !i_in.ready && !r_out_valid)
        else $error("item taken or result shown during the clearing pass");

    a_empty_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_empty |-> r_out_index == '0)
        else $error("empty draw carries a nonzero index");

    a_draw_from_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == wsst_pkg::ST_MUL) |-> r_total != '0)
        else $error("scaling started on an empty tree");

endmodule
`default_nettype wire

/* sim/tb.sv */
// testbench for the weighted sample sum tree: random writes and draws checked on a model tree
`timescale 1ns / 1ps
module tb;

    localparam int LEAF_COUNT  = 1024;
    localparam int LEAVES      = 1024;            // leaf count rounded up to a power of two
    localparam int SUM_W       = wsst_pkg::WGT_W + wsst_pkg::IDX_W;   // widest node sum
    localparam int REQ_TOTAL   = 1350;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_PCT    = 12;

    typedef struct {
        logic                         kind;
        bit [wsst_pkg::IDX_W-1:0]     object_index;
        bit [wsst_pkg::WGT_W-1:0]     weight;
        bit [wsst_pkg::RND_W-1:0]     random_fraction;
    } t_req_item;

    typedef struct {
        bit [wsst_pkg::IDX_W-1:0] chosen_index;
        bit                       nothing_left;
    } t_pick;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wsst_in_if  req_ch ();
    wsst_out_if pick_ch ();

    weighted_sample_sum_tree_core #(
        .LEAF_COUNT (LEAF_COUNT),
        .WEIGHT_BITS(wsst_pkg::WGT_W),
        .RANDOM_BITS(wsst_pkg::RND_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (pick_ch)
    );

    t_req_item   pending_reqs[$];
    t_pick       expected_picks[$];
    bit [SUM_W-1:0] model_sums[1:2*LEAVES-1];

    int accepted_cnt = 0;
    int picks_seen   = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int hold_left    = 0;
    bit hold_done    = 0;

    always #6 i_clk = ~i_clk;

    function automatic void note_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void queue_req(logic kind, bit [wsst_pkg::IDX_W-1:0] idx,
                                      bit [wsst_pkg::WGT_W-1:0] wgt,
                                      bit [wsst_pkg::RND_W-1:0] frac);
        t_req_item it;
        it.kind            = kind;
        it.object_index    = idx;
        it.weight          = wgt;
        it.random_fraction = frac;
        pending_reqs.push_back(it);
    endfunction

    // recompute every ancestor of a node up to the root
    function automatic void rebuild_path(int unsigned node);
        while (node > 1) begin
            node = node >> 1;
            model_sums[node] = model_sums[2*node] + model_sums[2*node+1];
        end
    endfunction

    // apply one accepted item to the model tree, queue the pick a draw must return
    function automatic void sum_tree_step(logic kind, bit [wsst_pkg::IDX_W-1:0] idx,
                                          bit [wsst_pkg::WGT_W-1:0] wgt,
                                          bit [wsst_pkg::RND_W-1:0] frac);
        int unsigned                        node;
        bit [SUM_W+wsst_pkg::RND_W-1:0]     prod;
        bit [SUM_W-1:0]                     target;
        t_pick                              pk;
        if (kind == wsst_pkg::KIND_WRITE) begin
            if (idx < LEAF_COUNT) begin
                node = LEAVES + idx;
                model_sums[node] = SUM_W'(wgt);
                rebuild_path(node);
            end
            return;
        end
        if (model_sums[1] == 0) begin
            pk.chosen_index = '0;
            pk.nothing_left = 1'b1;
            expected_picks.push_back(pk);
            return;
        end
        prod   = (SUM_W+wsst_pkg::RND_W)'(model_sums[1]) * (SUM_W+wsst_pkg::RND_W)'(frac);
        target = SUM_W'(prod >> wsst_pkg::RND_W);
        node   = 1;
        while (node < LEAVES) begin
            node = node * 2;
            if (target >= model_sums[node]) begin
                target = target - model_sums[node];
                node   = node + 1;
            end
        end
        pk.chosen_index = wsst_pkg::IDX_W'(node - LEAVES);
        pk.nothing_left = 1'b0;
        expected_picks.push_back(pk);
        // drawn leaf leaves the pool
        model_sums[node] = '0;
        rebuild_path(node);
    endfunction

    // request driver
    always @(posedge i_clk) begin : req_driver
        t_req_item nxt;
        bit        steady;
        if (!i_rst_n) begin
            req_ch.valid           <= 1'b0;
            req_ch.kind            <= wsst_pkg::KIND_WRITE;
            req_ch.object_index    <= '0;
            req_ch.weight          <= '0;
            req_ch.random_fraction <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                sum_tree_step(req_ch.kind, req_ch.object_index, req_ch.weight,
                              req_ch.random_fraction);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                steady = (accepted_cnt >= 500 && accepted_cnt < 700);
                if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_reqs.pop_front();
                    req_ch.kind            <= nxt.kind;
                    req_ch.object_index    <= nxt.object_index;
                    req_ch.weight          <= nxt.weight;
                    req_ch.random_fraction <= nxt.random_fraction;
                    req_ch.valid           <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && picks_seen >= 120) begin
            hold_left <= 700;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // pick monitor
    always @(posedge i_clk) begin : pick_monitor
        t_pick exp_pick;
        bit    steady;
        if (!i_rst_n) begin
            pick_ch.ready <= 1'b0;
        end else begin
            if (pick_ch.valid && pick_ch.ready) begin
                picks_seen <= picks_seen + 1;
                if (expected_picks.size() == 0) begin
                    note_error($sformatf("unexpected pick: index %0d empty %0b",
                                         pick_ch.chosen_index, pick_ch.nothing_left));
                end else begin
                    exp_pick = expected_picks.pop_front();
                    if (pick_ch.chosen_index !== exp_pick.chosen_index ||
                        pick_ch.nothing_left !== exp_pick.nothing_left) begin
                        note_error($sformatf(
                            "pick mismatch: expected index %0d empty %0b, got index %0d empty %0b",
                            exp_pick.chosen_index, exp_pick.nothing_left,
                            pick_ch.chosen_index, pick_ch.nothing_left));
                    end
                end
            end
            steady = (picks_seen >= 250 && picks_seen < 350);
            pick_ch.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int                       n;
        int                       draws;
        bit [wsst_pkg::IDX_W-1:0] base;
        bit [wsst_pkg::IDX_W-1:0] idx;
        bit [wsst_pkg::WGT_W-1:0] wgt;
        bit [wsst_pkg::RND_W-1:0] frac;

        i_rst_n = 1'b0;

        // directed: empty draws, extreme weights and fractions, zero weights, siblings
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'd0,    32'hFFFF_FFFF, $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'd1023, 32'hFFFF_FFFF, $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'd512,  32'h0,         $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'd511,  32'h1,         $urandom);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'h0);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'hFFFF_FFFF);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'h8000_0000);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'h0);
        queue_req(wsst_pkg::KIND_WRITE, 10'd5,    32'h7,         $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'd5,    32'h0,         $urandom);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'h2AA,  32'hAAAA_AAAA, $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'h155,  32'h5555_5555, $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'h3FF,  32'h1,         $urandom);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'h5555_5555);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'hAAAA_AAAA);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'hFFFF_FFFF);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'h0);
        queue_req(wsst_pkg::KIND_WRITE, 10'd1,    32'h1,         $urandom);
        queue_req(wsst_pkg::KIND_WRITE, 10'd0,    32'h1,         $urandom);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'h7FFF_FFFF);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, 32'h8000_0000);
        queue_req(wsst_pkg::KIND_DRAW,  wsst_pkg::IDX_W'($urandom), $urandom, $urandom);

        // random: mostly fill-then-draw-out episodes, some loose items
        while (pending_reqs.size() < REQ_TOTAL) begin
            if ($urandom_range(99) < 80) begin
                n    = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
                base = wsst_pkg::IDX_W'($urandom);
                for (int i = 0; i < n; i++) begin
                    // clustered indexes share most of their path to the root
                    idx = $urandom_range(1) ? wsst_pkg::IDX_W'(base + $urandom_range(15))
                                            : wsst_pkg::IDX_W'($urandom);
                    case ($urandom_range(5))
                        0: wgt = $urandom;
                        1: wgt = $urandom_range(1, 15);
                        2: wgt = 32'h1 << $urandom_range(31);
                        3: wgt = 32'hFFFF_FFFF;
                        4: wgt = $urandom_range(1);
                        default: wgt = $urandom >> $urandom_range(31);
                    endcase
                    queue_req(wsst_pkg::KIND_WRITE, idx, wgt, $urandom);
                end
                draws = n + $urandom_range(2);
                for (int i = 0; i < draws; i++) begin
                    case ($urandom_range(15))
                        0: frac = 32'h0;
                        1: frac = 32'hFFFF_FFFF;
                        default: frac = $urandom;
                    endcase
                    queue_req(wsst_pkg::KIND_DRAW, wsst_pkg::IDX_W'($urandom), $urandom, frac);
                end
            end else begin
                queue_req($urandom_range(1) ? wsst_pkg::KIND_DRAW : wsst_pkg::KIND_WRITE,
                          wsst_pkg::IDX_W'($urandom), $urandom, $urandom);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid) @(posedge i_clk);
        while (expected_picks.size() != 0) @(posedge i_clk);
        // a trailing write may still be rebuilding its path
        repeat (150) @(posedge i_clk);

        if (expected_picks.size() != 0) begin
            note_error($sformatf("%0d picks never arrived", expected_picks.size()));
        end
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
